// ===== src/atsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsw_pkg: shared types and constants for amount_to_spoken_word_tokens
// Token codes, controller states, and the command/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package atsw_pkg;

    localparam int AMOUNT_W      = 60;
    localparam int WORD_W        = 5;
    localparam int BITS_PER_STEP = 2;
    localparam int CONV_STEPS    = AMOUNT_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(CONV_STEPS + 1);
    localparam int LIMIT_W       = 64;

    // Token slots of one group, spoken lowest bit first.
    localparam int SLOT_N     = 7;
    localparam int SLOT_HDIG  = 0;
    localparam int SLOT_HUND  = 1;
    localparam int SLOT_LE    = 2;
    localparam int SLOT_TENS  = 3;
    localparam int SLOT_UNIT  = 4;
    localparam int SLOT_SCALE = 5;
    localparam int SLOT_CUR   = 6;

    localparam logic [WORD_W-1:0] TOK_ZERO       = 5'd0;
    localparam logic [WORD_W-1:0] TOK_TENS_BASE  = 5'd9;
    localparam logic [WORD_W-1:0] TOK_MOT2       = 5'd19;
    localparam logic [WORD_W-1:0] TOK_LAM        = 5'd20;
    localparam logic [WORD_W-1:0] TOK_LE         = 5'd21;
    localparam logic [WORD_W-1:0] TOK_HUNDRED    = 5'd22;
    localparam logic [WORD_W-1:0] TOK_SCALE_BASE = 5'd22;
    localparam logic [WORD_W-1:0] TOK_CURRENCY   = 5'd28;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_ERR,
        ST_GROUP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic err_emit;
        logic grp_load;
        logic grp_next;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic too_big;
        logic conv_last;
        logic out_free;
        logic mask_empty;
        logic mask_one;
        logic grp_zero;
    } t_status;

    // 1000^n, evaluated at elaboration only.
    function automatic logic [LIMIT_W-1:0] pow1000(input int n);
        logic [LIMIT_W-1:0] p;
        p = LIMIT_W'(1);
        for (int k = 0; k < n; k++) begin
            p = p * LIMIT_W'(1000);
        end
        return p;
    endfunction

endpackage

// ===== src/atsw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsw_ctrl: sequencing controller
// Walks one amount through range check, BCD conversion and per-group token
// emission, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module atsw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  atsw_pkg::t_status i_st,
    output atsw_pkg::t_cmd    o_cmd
);

    atsw_pkg::t_state r_state;
    atsw_pkg::t_state n_state;
    logic             grp_done;

    // current group finishes this cycle
    assign grp_done = i_st.mask_empty || (i_st.out_free && i_st.mask_one);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atsw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            atsw_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = atsw_pkg::ST_CONV;
            end
            atsw_pkg::ST_CONV: begin
                if (i_st.too_big)        n_state = atsw_pkg::ST_ERR;
                else if (i_st.conv_last) n_state = atsw_pkg::ST_GROUP;
            end
            atsw_pkg::ST_ERR: begin
                if (i_st.out_free) n_state = atsw_pkg::ST_IDLE;
            end
            atsw_pkg::ST_GROUP: begin
                n_state = atsw_pkg::ST_EMIT;
            end
            atsw_pkg::ST_EMIT: begin
                if (grp_done) begin
                    n_state = i_st.grp_zero ? atsw_pkg::ST_IDLE : atsw_pkg::ST_GROUP;
                end
            end
            default: n_state = atsw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            atsw_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            atsw_pkg::ST_CONV: begin
                o_cmd.shift = !i_st.too_big;
            end
            atsw_pkg::ST_ERR: begin
                o_cmd.err_emit = i_st.out_free;
            end
            atsw_pkg::ST_GROUP: begin
                o_cmd.grp_load = 1'b1;
            end
            atsw_pkg::ST_EMIT: begin
                o_cmd.emit     = !i_st.mask_empty && i_st.out_free;
                o_cmd.grp_next = grp_done && !i_st.grp_zero;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit || o_cmd.err_emit) |-> i_st.out_free)
        else $error("token issued while output register busy");

    a_big_goes_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atsw_pkg::ST_CONV && i_st.too_big) |=> r_state == atsw_pkg::ST_ERR)
        else $error("out-of-range amount did not take the error path");

endmodule

// ===== src/atsw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsw_dp: conversion and token datapath
// Double-dabble converter (two bits per cycle), group slot mask, token
// selection and the output register.
// ----------------------------------------------------------------------------
module atsw_dp #(
    parameter int MAX_GROUPS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  atsw_pkg::t_cmd               i_cmd,
    output atsw_pkg::t_status            o_st,
    input  logic [atsw_pkg::AMOUNT_W-1:0] i_amount,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [atsw_pkg::WORD_W-1:0]  o_word,
    output logic                         o_last,
    output logic                         o_error
);

    localparam int NDIG  = 3 * MAX_GROUPS;
    localparam int BCD_W = 4 * NDIG;
    localparam int GRP_W = $clog2(MAX_GROUPS + 1);
    localparam logic [atsw_pkg::LIMIT_W-1:0] LIMIT = atsw_pkg::pow1000(MAX_GROUPS);

    logic [atsw_pkg::AMOUNT_W-1:0] r_bin;
    logic [BCD_W-1:0]              r_bcd;
    logic [atsw_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_too_big;
    logic [GRP_W-1:0]              r_grp;
    logic                          r_lead;
    logic [3:0]                    r_h;
    logic [3:0]                    r_t;
    logic [3:0]                    r_u;
    logic [atsw_pkg::SLOT_N-1:0]   r_mask;
    logic                          r_valid;
    logic [atsw_pkg::WORD_W-1:0]   r_word;
    logic                          r_last;
    logic                          r_error;

    logic [3:0]                    g_h;
    logic [3:0]                    g_t;
    logic [3:0]                    g_u;
    logic                          rest_nz;
    logic                          g_nz;
    logic                          leading;
    logic                          idx0;
    logic [atsw_pkg::SLOT_N-1:0]   n_mask;
    logic [atsw_pkg::SLOT_N-1:0]   sel;
    logic [atsw_pkg::WORD_W-1:0]   unit_tok;
    logic [atsw_pkg::WORD_W-1:0]   n_word;

    // one double-dabble step: add 3 to digits of 5 or more, shift in a bit
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
                                                input logic bit_in);
        logic [BCD_W-1:0] a;
        a = b;
        for (int d = 0; d < NDIG; d++) begin
            if (a[4*d +: 4] >= 4'd5) a[4*d +: 4] = a[4*d +: 4] + 4'd3;
        end
        return {a[BCD_W-2:0], bit_in};
    endfunction

    // top group of the BCD register is always the next one to speak
    assign g_h     = r_bcd[BCD_W-1 -: 4];
    assign g_t     = r_bcd[BCD_W-5 -: 4];
    assign g_u     = r_bcd[BCD_W-9 -: 4];
    assign rest_nz = (g_t != 4'd0) || (g_u != 4'd0);
    assign g_nz    = (g_h != 4'd0) || rest_nz;
    assign leading = !r_lead;
    assign idx0    = (r_grp == '0);

    always_comb begin
        n_mask = '0;
        n_mask[atsw_pkg::SLOT_HDIG]  = (g_h != 4'd0) || (!leading && rest_nz);
        n_mask[atsw_pkg::SLOT_HUND]  = (g_h != 4'd0) || (!leading && rest_nz);
        n_mask[atsw_pkg::SLOT_LE]    = (g_h != 4'd0) && (g_t == 4'd0) && (g_u != 4'd0);
        n_mask[atsw_pkg::SLOT_TENS]  = (g_t != 4'd0);
        // zero amount: leading lowest group says a bare zero
        n_mask[atsw_pkg::SLOT_UNIT]  = (g_u != 4'd0) || (idx0 && leading && !g_nz);
        n_mask[atsw_pkg::SLOT_SCALE] = g_nz && !idx0;
        n_mask[atsw_pkg::SLOT_CUR]   = idx0;
    end

    assign sel = r_mask & (~r_mask + 1'b1);

    always_comb begin
        if (r_t == 4'd0)                     unit_tok = {1'b0, r_u};
        else if (r_t >= 4'd2 && r_u == 4'd1) unit_tok = atsw_pkg::TOK_MOT2;
        else if (r_u == 4'd5)                unit_tok = atsw_pkg::TOK_LAM;
        else                                 unit_tok = {1'b0, r_u};
    end

    always_comb begin
        if (sel[atsw_pkg::SLOT_HDIG])       n_word = {1'b0, r_h};
        else if (sel[atsw_pkg::SLOT_HUND])  n_word = atsw_pkg::TOK_HUNDRED;
        else if (sel[atsw_pkg::SLOT_LE])    n_word = atsw_pkg::TOK_LE;
        else if (sel[atsw_pkg::SLOT_TENS])  n_word = atsw_pkg::TOK_TENS_BASE + {1'b0, r_t};
        else if (sel[atsw_pkg::SLOT_UNIT])  n_word = unit_tok;
        else if (sel[atsw_pkg::SLOT_SCALE]) n_word = atsw_pkg::TOK_SCALE_BASE
                                                     + atsw_pkg::WORD_W'(r_grp);
        else                                n_word = atsw_pkg::TOK_CURRENCY;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_too_big <= 1'b0;
            r_grp     <= '0;
            r_lead    <= 1'b0;
            r_mask    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cnt     <= atsw_pkg::CNT_W'(atsw_pkg::CONV_STEPS);
                r_too_big <= {{(atsw_pkg::LIMIT_W - atsw_pkg::AMOUNT_W){1'b0}}, i_amount}
                             >= LIMIT;
                r_grp     <= GRP_W'(MAX_GROUPS - 1);
                r_lead    <= 1'b0;
                r_mask    <= '0;
            end
            if (i_cmd.shift) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.grp_load) begin
                r_mask <= n_mask;
                r_lead <= r_lead | g_nz;
            end
            if (i_cmd.emit) begin
                r_mask <= r_mask & ~sel;
            end
            if (i_cmd.grp_next) begin
                r_grp <= r_grp - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_amount;
            r_bcd <= '0;
        end
        if (i_cmd.shift) begin
            r_bin <= {r_bin[atsw_pkg::AMOUNT_W-3:0], 2'b00};
            r_bcd <= dabble(dabble(r_bcd, r_bin[atsw_pkg::AMOUNT_W-1]),
                            r_bin[atsw_pkg::AMOUNT_W-2]);
        end
        if (i_cmd.grp_load) begin
            r_h   <= g_h;
            r_t   <= g_t;
            r_u   <= g_u;
            r_bcd <= r_bcd << 12;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.err_emit) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_emit) begin
            r_word  <= atsw_pkg::TOK_ZERO;
            r_last  <= 1'b1;
            r_error <= 1'b1;
        end else if (i_cmd.emit) begin
            r_word  <= n_word;
            r_last  <= sel[atsw_pkg::SLOT_CUR];
            r_error <= 1'b0;
        end
    end

    assign o_st.too_big    = r_too_big;
    assign o_st.conv_last  = (r_cnt == atsw_pkg::CNT_W'(1));
    assign o_st.out_free   = !r_valid || !i_stall;
    assign o_st.mask_empty = (r_mask == '0);
    assign o_st.mask_one   = (r_mask != '0) && ((r_mask & (r_mask - 1'b1)) == '0);
    assign o_st.grp_zero   = idx0;

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_last  = r_last;
    assign o_error = r_error;

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_error) |-> (r_last && r_word == atsw_pkg::TOK_ZERO))
        else $error("error transaction not a lone zero token");

    a_emit_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_mask != '0))
        else $error("emit with no pending slot");

    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.grp_load |-> (r_mask == '0))
        else $error("group loaded over unfinished slots");

endmodule

// ===== src/amount_to_spoken_word_tokens.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amount_to_spoken_word_tokens: money amount to Vietnamese spoken-word tokens
// Converts one unsigned amount into a run of word tokens ending with the
// currency token, or a single error transaction when out of range.
// ----------------------------------------------------------------------------
// Usage: present an amount on i_amount with i_in_valid; it is taken on an
// edge where o_in_stall is low. The block handles one amount at a time and
// holds o_in_stall high until the last token of that amount has been loaded
// into the output register, so the next amount can be taken while that final
// token is still waiting downstream. Tokens leave one per transaction on
// o_word with o_last marking the final one; o_error marks the lone error
// transaction sent for amounts of 1000^MAX_GROUPS or more (word 0, last 1).
// Sequence per amount: the accept in ST_IDLE, then binary-to-BCD conversion in
// ST_CONV (double dabble, two bits per cycle over 60 bits), then for each of
// the MAX_GROUPS three-digit groups a load in ST_GROUP and its tokens in
// ST_EMIT, where a group that says nothing still passes through ST_EMIT. A
// group speaks at most five tokens. An out-of-range amount leaves ST_CONV
// for ST_ERR before any conversion step.
// Output stalls hold back emission.
// ----------------------------------------------------------------------------
module amount_to_spoken_word_tokens #(
    parameter int MAX_GROUPS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // amount channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [atsw_pkg::AMOUNT_W-1:0] i_amount,
    // token channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [atsw_pkg::WORD_W-1:0]   o_word,
    output logic                          o_last,
    output logic                          o_error
);

    // controller <-> datapath handshake bundles
    atsw_pkg::t_cmd    cmd;
    atsw_pkg::t_status st;

    // Sequencer: range check, conversion, then group-by-group emission.
    atsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // BCD converter, group slot logic and the output register.
    atsw_dp #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_st     (st),
        .i_amount (i_amount),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_word   (o_word),
        .o_last   (o_last),
        .o_error  (o_error)
    );

endmodule
